@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, suspended while rst is high.
`define CCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Property checked at every rising edge of clk, reset cycles included.
`define CCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

@@ sv/ccc_pkg.sv @@
// Shared types, widths and codes of the circle collision checker.
package ccc_pkg;

  // Table size, the count register width and the widths that follow from them.
  localparam int MAX_ROBOTS  = 256;
  localparam int ADDR_W      = $clog2(MAX_ROBOTS);
  localparam int CNT_W       = $clog2(MAX_ROBOTS + 1);
  localparam int COUNT_REG_W = 9;
  localparam int WIDE_W      = (CNT_W > COUNT_REG_W) ? CNT_W : COUNT_REG_W;

  // Field widths.
  localparam int IDX_W      = 8;
  localparam int COORD_W    = 20;
  localparam int RADIUS_W   = 16;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 2 * COORD_W;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = 2 * COORD_W + 1;
  localparam int TWICE_W    = RADIUS_W + 1;
  localparam int LIM_W      = 2 * TWICE_W;
  localparam int S_TDATA_W  = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((KIND_W + IDX_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_RADIUS = CFG_IDX_W'(3);

  // Register values after reset.
  localparam logic [COUNT_REG_W-1:0] RST_ROBOT_COUNT  = COUNT_REG_W'(2);
  localparam logic [COORD_W-1:0]     RST_SPAN_X       = COORD_W'(38400);
  localparam logic [COORD_W-1:0]     RST_SPAN_Y       = COORD_W'(38400);
  localparam logic [RADIUS_W-1:0]    RST_ROBOT_RADIUS = RADIUS_W'(256);

  // Item kind carried on the input tuser.
  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Answer codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_ROBOT = 2'd1,
    KIND_WALL  = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic query_start;
    logic read_self;
    logic latch_self;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wall;
    logic scan_done;
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/ccc_ctrl.sv @@
// Controller state machine that sequences stores and collision queries.
module ccc_ctrl
  import ccc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       s_tuser,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELF_RD,
    ST_SELF_LATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == CMD_STORE)) begin
          cmd.store = 1'b1;
        end else if (accept) begin
          cmd.query_start = 1'b1;
          state_next      = ST_SELF_RD;
        end
      end
      ST_SELF_RD: begin
        cmd.read_self = 1'b1;
        state_next    = ST_SELF_LATCH;
      end
      ST_SELF_LATCH: begin
        cmd.latch_self = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (status.wall) begin
          state_next = ST_DONE;
        end else if (status.scan_done) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/ccc_dp.sv @@
// Datapath: configuration registers, position table, distance pipeline, result register.
module ccc_dp
  import ccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata
);

  // Configuration registers.
  logic [COUNT_REG_W-1:0] robot_count;
  logic [COORD_W-1:0]     span_x;
  logic [COORD_W-1:0]     span_y;
  logic [RADIUS_W-1:0]    robot_radius;

  // Input item fields.
  logic [IDX_W-1:0]   in_idx;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [WIDE_W-1:0]  in_idx_wide;
  logic               in_range;

  // Position table and its registered read port.
  logic [POS_W-1:0]  mem [MAX_ROBOTS];
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  rd_data;

  // Query context.
  logic [IDX_W-1:0]   self_idx;
  logic [WIDE_W-1:0]  self_wide;
  logic               self_ok;
  logic [WIDE_W-1:0]  n_eff;
  logic [WIDE_W-1:0]  cnt_wide;
  logic [WIDE_W-1:0]  max_wide;
  logic [COORD_W-1:0] self_x;
  logic [COORD_W-1:0] self_y;
  logic [COORD_W-1:0] sx;
  logic [COORD_W-1:0] sy;
  logic               wall_next;
  logic               wall;
  logic [WIDE_W-1:0]  scan_idx;

  // Limit on the squared distance.
  logic [TWICE_W-1:0] twice;
  logic [LIM_W-1:0]   lim_sq;

  // Distance pipeline.
  logic               v1;
  logic               v2;
  logic               v3;
  logic [COORD_W-1:0] rd_x;
  logic [COORD_W-1:0] rd_y;
  logic [COORD_W-1:0] dx_next;
  logic [COORD_W-1:0] dy_next;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [SQ_W-1:0]    sqx;
  logic [SQ_W-1:0]    sqy;
  logic [DIST_W-1:0]  dist_sq;
  logic               hit;
  kind_t              kind;

  // Configuration writes; cfg_ready is always high.
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_count  <= RST_ROBOT_COUNT;
      span_x       <= RST_SPAN_X;
      span_y       <= RST_SPAN_Y;
      robot_radius <= RST_ROBOT_RADIUS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROBOT_COUNT:  robot_count  <= cfg_data[COUNT_REG_W-1:0];
        REG_SPAN_X:       span_x       <= cfg_data[COORD_W-1:0];
        REG_SPAN_Y:       span_y       <= cfg_data[COORD_W-1:0];
        REG_ROBOT_RADIUS: robot_radius <= cfg_data[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the input transfer.
  assign in_idx      = s_tdata[IDX_W-1:0];
  assign in_x        = s_tdata[IDX_W +: COORD_W];
  assign in_y        = s_tdata[IDX_W + COORD_W +: COORD_W];
  assign in_idx_wide = WIDE_W'(in_idx);
  assign in_range    = in_idx_wide < WIDE_W'(MAX_ROBOTS);

  // Table read address: the queried robot first, then the scan counter.
  assign rd_addr = cmd.read_self ? ADDR_W'(self_wide) : scan_idx[ADDR_W-1:0];

  // Position table: x in the low half, y in the high half.
  always_ff @(posedge clk) begin
    if (cmd.store && in_range) begin
      mem[ADDR_W'(in_idx_wide)] <= {in_y, in_x};
    end
    rd_data <= mem[rd_addr];
  end

  // Squared limit (2r)^2, kept up to date from the radius register.
  assign twice = {robot_radius, 1'b0};

  always_ff @(posedge clk) begin
    lim_sq <= twice * twice;
  end

  // Clamp the robot count to the table depth.
  assign cnt_wide = WIDE_W'(robot_count);
  assign max_wide = WIDE_W'(MAX_ROBOTS);

  // Queried robot position; an index beyond the table reads as the origin.
  assign sx = self_ok ? rd_data[COORD_W-1:0] : '0;
  assign sy = self_ok ? rd_data[POS_W-1:COORD_W] : '0;

  // Wall test, with the sums one bit wider so that nothing wraps.
  assign wall_next =
      (sx <= COORD_W'(robot_radius)) ||
      ((COORD_W+1)'(sx) + (COORD_W+1)'(robot_radius) >= (COORD_W+1)'(span_x)) ||
      (sy <= COORD_W'(robot_radius)) ||
      ((COORD_W+1)'(sy) + (COORD_W+1)'(robot_radius) >= (COORD_W+1)'(span_y));

  // Query context registers.
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      self_idx  <= in_idx;
      self_wide <= in_idx_wide;
      self_ok   <= in_range;
      n_eff     <= (cnt_wide > max_wide) ? max_wide : cnt_wide;
    end
    if (cmd.latch_self) begin
      self_x <= sx;
      self_y <= sy;
    end
  end

  // Scan counter and wall flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      wall     <= 1'b0;
    end else if (cmd.latch_self) begin
      scan_idx <= '0;
      wall     <= wall_next;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + WIDE_W'(1);
    end
  end

  // Absolute coordinate differences against the entry just read.
  assign rd_x    = rd_data[COORD_W-1:0];
  assign rd_y    = rd_data[POS_W-1:COORD_W];
  assign dx_next = (self_x >= rd_x) ? (self_x - rd_x) : (rd_x - self_x);
  assign dy_next = (self_y >= rd_y) ? (self_y - rd_y) : (rd_y - self_y);
  assign dist_sq = DIST_W'(sqx) + DIST_W'(sqy);

  // Pipeline valid bits; the queried robot itself is never compared.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue && (scan_idx != self_wide);
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Difference and square stages.
  always_ff @(posedge clk) begin
    dx  <= dx_next;
    dy  <= dy_next;
    sqx <= dx * dx;
    sqy <= dy * dy;
  end

  // Overlap flag collects every compared entry.
  always_ff @(posedge clk) begin
    if (rst || cmd.latch_self) begin
      hit <= 1'b0;
    end else if (v3 && (dist_sq < DIST_W'(lim_sq))) begin
      hit <= 1'b1;
    end
  end

  // Answer code.
  always_comb begin
    priority if (wall) begin
      kind = KIND_WALL;
    end else if (hit) begin
      kind = KIND_ROBOT;
    end else begin
      kind = KIND_NONE;
    end
  end

  // Result register on the output side.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {(M_TDATA_W - KIND_W - IDX_W)'(0), self_idx, kind};
    end
  end

  // Status back to the controller.
  assign status.wall       = wall;
  assign status.scan_done  = !(scan_idx < n_eff);
  assign status.pipe_empty = !(v1 || v2 || v3);
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

@@ sv/circle_collision_checker.sv @@
// Circle collision checker top level. It keeps a table of robot positions
// and answers collision queries. A store transfer (tuser low) writes one
// robot's x and y into the table and gives no result. A query transfer
// (tuser high) gives one result: wall when the robot lies within the radius
// of an arena edge, robot when another entry below the robot count is
// closer than twice the radius, none otherwise. A query first reads the
// robot's own entry and tests the walls, then, unless the robot touches a
// wall, walks the table one entry per cycle through its single read port
// and a distance pipeline of difference, square and compare stages. One
// item is worked on at a time; the result sits in an output register, so
// the next item is taken as soon as that register is loaded. Configuration
// writes are taken every cycle and must only be made while the block is
// idle. Coordinates are unsigned with four fraction bits.
module circle_collision_checker
  import ccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // robot_index, pos_x, pos_y
  input  logic                  s_tuser,  // cmd
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata   // collision_kind, queried_index, zero pad
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  ccc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  ccc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ sv/ccc_checker.sv @@
// Port-level checker for the circle collision checker and its bind.
`include "assert_macros.svh"

module ccc_checker
  import ccc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // No result is shown in the cycle after reset.
  `CCC_ASSERT_ALWAYS(a_no_result_after_reset, $past(rst) |-> !m_tvalid)

  // A waiting result holds until its transfer.
  `CCC_ASSERT(a_result_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

  // A query transfer blocks further input while it is worked on.
  `CCC_ASSERT(a_query_busy, (s_tvalid && s_tready && s_tuser) |=> !s_tready)

  // A store transfer never brings up a result.
  `CCC_ASSERT(a_store_silent, (s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)

endmodule

bind circle_collision_checker ccc_checker u_ccc_checker (.*);
